### sv/h2p_pkg.sv
// Shared constants and elaboration-time helpers for the Halton point generator.
// Has no dependencies; imported by the top level.
package h2p_pkg;

  // Result fields never carry more than this many fraction bits.
  localparam int OUT_LIMIT_BITS = 24;

  // Power of three, evaluated at elaboration.
  function automatic longint unsigned pow3(input int k);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd3;
    end
    return p;
  endfunction

  // Number of ternary digits needed to hold any index of the given width.
  function automatic int digit_count(input int width);
    longint unsigned p;
    longint unsigned lim;
    int k;
    p = 64'd1;
    lim = 64'd1 << width;
    k = 0;
    while (p < lim) begin
      p = p * 64'd3;
      k = k + 1;
    end
    return k;
  endfunction

endpackage

### sv/halton_2d_point_top.sv
// Top level of the two-dimensional Halton point generator (bases 2 and 3).
// Depends on h2p_pkg, h2p_digit_stage and h2p_div_stage.
//
// Each index word yields one point word: x_fraction is the index's bits
// mirrored about the binary point, y_fraction the base-3 radical inverse,
// both unsigned truncated fractions with FRAC_BITS fraction bits (bits above
// the 24th are always zero). The pipeline accepts one word per cycle while
// the output is not stalled. It has one stage per ternary digit (11 for a
// 16-bit index), then one stage per long-division step of the fraction (24
// by default). Every stage keeps its own valid bit, so a stalled output
// holds its point and earlier stages keep filling gaps. Reset only clears
// the valid bits.
module halton_2d_point_top import h2p_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_BITS-1:0]  x_fraction,
  output logic [FRAC_BITS-1:0]  y_fraction
);

  localparam int NDIG = digit_count(INDEX_BITS);
  localparam longint unsigned DEN = pow3(NDIG);
  localparam int NUM_BITS = $clog2(DEN);
  localparam int KEEP_BITS = (FRAC_BITS < OUT_LIMIT_BITS) ? FRAC_BITS : OUT_LIMIT_BITS;
  localparam logic [FRAC_BITS-1:0] OUT_MASK =
    FRAC_BITS'((64'd1 << KEEP_BITS) - 64'd1);

  // Links between the digit stages.
  logic                  dv   [NDIG+1];
  logic                  dr   [NDIG+1];
  logic [INDEX_BITS-1:0] dn   [NDIG+1];
  logic [NUM_BITS-1:0]   dnum [NDIG+1];
  logic [FRAC_BITS-1:0]  dx   [NDIG+1];

  // Links between the division stages.
  logic                  qv   [FRAC_BITS+1];
  logic                  qr   [FRAC_BITS+1];
  logic [NUM_BITS-1:0]   qrem [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]  qquo [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]  qx   [FRAC_BITS+1];

  logic [INDEX_BITS-1:0] rev;
  logic [FRAC_BITS-1:0]  x_first;

  // Mirror the index bits; x then aligns to the fraction width.
  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      rev[i] = index[INDEX_BITS-1-i];
    end
  end

  generate
    if (FRAC_BITS >= INDEX_BITS) begin : g_x_wide
      assign x_first = FRAC_BITS'({rev, {(FRAC_BITS - INDEX_BITS + 1){1'b0}}} >> 1);
    end else begin : g_x_narrow
      assign x_first = rev[INDEX_BITS-1 -: FRAC_BITS];
    end
  endgenerate

  // Input side of the digit chain.
  assign dv[0]   = in_valid;
  assign in_ready = dr[0];
  assign dn[0]   = index;
  assign dnum[0] = '0;
  assign dx[0]   = x_first;

  // Digit i carries the weight of its mirrored place.
  generate
    for (genvar i = 0; i < NDIG; i++) begin : g_digit
      h2p_digit_stage #(
        .INDEX_BITS (INDEX_BITS),
        .NUM_BITS   (NUM_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .WEIGHT     (pow3(NDIG - 1 - i))
      ) u_digit (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (dv[i]),
        .in_ready  (dr[i]),
        .in_n      (dn[i]),
        .in_num    (dnum[i]),
        .in_x      (dx[i]),
        .out_valid (dv[i+1]),
        .out_ready (dr[i+1]),
        .out_n     (dn[i+1]),
        .out_num   (dnum[i+1]),
        .out_x     (dx[i+1])
      );
    end
  endgenerate

  // The full numerator enters the divider over the fixed power of three.
  assign qv[0]    = dv[NDIG];
  assign dr[NDIG] = qr[0];
  assign qrem[0]  = dnum[NDIG];
  assign qquo[0]  = '0;
  assign qx[0]    = dx[NDIG];

  generate
    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
      h2p_div_stage #(
        .NUM_BITS  (NUM_BITS),
        .FRAC_BITS (FRAC_BITS),
        .DEN       (DEN)
      ) u_div (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (qv[j]),
        .in_ready  (qr[j]),
        .in_rem    (qrem[j]),
        .in_quo    (qquo[j]),
        .in_x      (qx[j]),
        .out_valid (qv[j+1]),
        .out_ready (qr[j+1]),
        .out_rem   (qrem[j+1]),
        .out_quo   (qquo[j+1]),
        .out_x     (qx[j+1])
      );
    end
  endgenerate

  // Output side: the last division stage is the output register.
  assign out_valid     = qv[FRAC_BITS];
  assign qr[FRAC_BITS] = out_ready;
  assign x_fraction    = qx[FRAC_BITS] & OUT_MASK;
  assign y_fraction    = qquo[FRAC_BITS] & OUT_MASK;

endmodule

### sv/h2p_digit_stage.sv
// One pipeline stage that peels off a single base-3 digit of the index.
// Standalone; its digit weight comes in as a parameter from the top level.
module h2p_digit_stage #(
  parameter int INDEX_BITS = 16,
  parameter int NUM_BITS = 18,
  parameter int FRAC_BITS = 24,
  parameter longint unsigned WEIGHT = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_n,
  input  logic [NUM_BITS-1:0]   in_num,
  input  logic [FRAC_BITS-1:0]  in_x,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_BITS-1:0] out_n,
  output logic [NUM_BITS-1:0]   out_num,
  output logic [FRAC_BITS-1:0]  out_x
);

  // Reciprocal of three, exact for every index of this width with a
  // shift of INDEX_BITS+1.
  localparam logic [INDEX_BITS-1:0] RECIP =
    INDEX_BITS'(((64'd1 << (INDEX_BITS + 1)) + 64'd2) / 64'd3);
  localparam logic [NUM_BITS-1:0] W1 = NUM_BITS'(WEIGHT);
  localparam logic [NUM_BITS-1:0] W2 = NUM_BITS'(WEIGHT * 64'd2);

  logic [2*INDEX_BITS-1:0] prod;
  logic [INDEX_BITS-2:0]   quot;
  logic [1:0]              digit;
  logic [NUM_BITS-1:0]     num_next;

  // Quotient by multiplication, then the digit from the low two bits only.
  always_comb begin
    prod  = {{INDEX_BITS{1'b0}}, in_n} * {{INDEX_BITS{1'b0}}, RECIP};
    quot  = prod[2*INDEX_BITS-1:INDEX_BITS+1];
    digit = in_n[1:0] - (quot[1:0] + {quot[0], 1'b0});
    unique case (digit)
      2'd1:    num_next = in_num + W1;
      2'd2:    num_next = in_num + W2;
      default: num_next = in_num;
    endcase
  end

  // The stage takes a word whenever it is empty or its word moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_n   <= {1'b0, quot};
      out_num <= num_next;
      out_x   <= in_x;
    end
  end

endmodule

### sv/h2p_div_stage.sv
// One restoring long-division step that yields one fraction bit of y.
// Standalone; the divisor comes in as a parameter from the top level.
module h2p_div_stage #(
  parameter int NUM_BITS = 18,
  parameter int FRAC_BITS = 24,
  parameter longint unsigned DEN = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_BITS-1:0]  in_rem,
  input  logic [FRAC_BITS-1:0] in_quo,
  input  logic [FRAC_BITS-1:0] in_x,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NUM_BITS-1:0]  out_rem,
  output logic [FRAC_BITS-1:0] out_quo,
  output logic [FRAC_BITS-1:0] out_x
);

  localparam logic [NUM_BITS:0] DIVISOR = (NUM_BITS + 1)'(DEN);

  logic [NUM_BITS:0] shifted;
  logic [NUM_BITS:0] diff;
  logic              take;

  // Double the remainder and subtract the divisor where it fits.
  always_comb begin
    shifted = {in_rem, 1'b0};
    take    = shifted >= DIVISOR;
    diff    = shifted - DIVISOR;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem <= take ? diff[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
      out_quo <= {in_quo[FRAC_BITS-2:0], take};
      out_x   <= in_x;
    end
  end

endmodule

### verif/halton_2d_point_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for halton_2d_point_top: predicts every point from its index.
// Depends on h2p_pkg, halton_2d_point_top, h2p_digit_stage and h2p_div_stage.
module halton_2d_point_top_tb import h2p_pkg::*;;

  localparam int INDEX_W = 16;
  localparam int FRAC_W = OUT_LIMIT_BITS;
  localparam int PIPE_DEPTH = 35;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [FRAC_W-1:0] frac_t;

  typedef struct {
    index_t idx;
    frac_t  x;
    frac_t  y;
  } point_t;

  // Holds the predicted points in order and compares each delivered word.
  class point_scoreboard;
    point_t expected_points[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Bits of the index mirrored about the binary point, widened to FRAC_W bits.
    function frac_t base2_inverse(index_t idx);
      index_t rev;
      for (int i = 0; i < INDEX_W; i++) begin
        rev[INDEX_W-1-i] = idx[i];
      end
      return {rev, {(FRAC_W-INDEX_W){1'b0}}};
    endfunction

    // Ternary digits mirrored about the ternary point, then one exact truncation.
    function frac_t base3_inverse(index_t idx);
      longint unsigned n;
      longint unsigned num;
      longint unsigned den;
      frac_t q;
      n = idx;
      num = 0;
      den = 1;
      q = '0;
      while (n > 0) begin
        num = num * 3 + (n % 3);
        den = den * 3;
        n = n / 3;
      end
      for (int i = 0; i < FRAC_W; i++) begin
        num = num << 1;
        q = q << 1;
        if (num >= den) begin
          num = num - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void note_index(index_t idx);
      point_t p;
      p.idx = idx;
      p.x = base2_inverse(idx);
      p.y = base3_inverse(idx);
      expected_points.insert(expected_points.size(), p);
    endfunction

    function void check_point(frac_t x, frac_t y);
      point_t p;
      if (expected_points.size() == 0) begin
        $display("%0t: point word with none expected: x=%h y=%h", $time, x, y);
        errors++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.x) begin
        $display("%0t: index %h x_fraction expected %h actual %h", $time, p.idx, p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $display("%0t: index %h y_fraction expected %h actual %h", $time, p.idx, p.y, y);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_points.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  index_t index = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  frac_t  x_fraction;
  frac_t  y_fraction;
  logic   hold_req = 1'b0;

  point_scoreboard sb = new();

  halton_2d_point_top #(
    .INDEX_BITS(INDEX_W),
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .index(index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .x_fraction(x_fraction),
    .y_fraction(y_fraction)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort the run if it goes far past the slowest legal completion.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: checks each accepted point word, stalls on shifting patterns and holds off on request.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit hold_seen;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_point(x_fraction, y_fraction);
      end
      if (hold_req && !hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (!hold_req) begin
        hold_seen = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 4);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        unique case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 9) != 0);
          3: out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // Present one index word and hold it until the block takes it.
  task automatic offer_index(input index_t v);
    in_valid <= 1'b1;
    index <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_index(v);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Mix of uniform indices, small ones, and ones near powers of three and two.
  function automatic index_t pick_index();
    int sel;
    int k;
    longint unsigned p;
    sel = $urandom_range(0, 99);
    p = 1;
    if (sel < 50) begin
      return index_t'($urandom());
    end else if (sel < 70) begin
      return index_t'($urandom_range(0, 80));
    end else if (sel < 85) begin
      k = $urandom_range(1, 10);
      for (int i = 0; i < k; i++) begin
        p = p * 3;
      end
      return index_t'(p + $urandom_range(0, 4) - 2);
    end else begin
      k = $urandom_range(0, INDEX_W - 1);
      p = longint'(1) << k;
      return index_t'(p + $urandom_range(0, 2) - 1);
    end
  endfunction

  task automatic random_phase(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        offer_index(pick_index());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 15));
      end
    end
  endtask

  // Extremes, single bits, alternating patterns and powers of three around the edges.
  index_t directed_indices[] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0008,
    16'h8000, 16'h4000, 16'hFFFF, 16'hFFFE, 16'h7FFF, 16'h5555,
    16'hAAAA, 16'h0009, 16'h001B, 16'h0050, 16'h2AAB, 16'hE6A9,
    16'hE6A8, 16'hE6AA, 16'h3FFF, 16'h00FF, 16'hFF00
  };

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_indices[i]) begin
      offer_index(directed_indices[i]);
      idle_sender($urandom_range(0, 3));
    end
    // Let the pipeline empty completely before the random traffic.
    drain_points();

    random_phase(800);

    // Long output stall while words keep coming, so the pipeline backs up.
    hold_req <= 1'b1;
    for (int i = 0; i < 120; i++) begin
      offer_index(pick_index());
    end
    hold_req <= 1'b0;
    drain_points();

    random_phase(800);

    drain_points();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
